[src/bitmap_slot_allocator_unit_defines.svh]
// Assertion macros used by the slot allocator sequencer.
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Check a property in the same cycle as its trigger.
`define BSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// Check a property in the cycle after its trigger.
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

[src/bsa_pkg.sv]
// Package: constants and types of the bitmap slot allocator.
package bsa_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int MAX_RUN   = 32;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int LIMIT_W   = 7;
   localparam int COUNT_W   = 6;
   localparam int ALIGN_W   = 7;
   // candidate offset may step past the limit by up to one align step
   localparam int CAND_W    = LIMIT_W + 1;

   localparam logic [LIMIT_W-1:0] TOTAL_SLOTS_RESET = LIMIT_W'(MAX_SLOTS);

   localparam logic KIND_RESERVE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // bitmap update request from the sequencer
   typedef struct packed {
      logic set;
      logic clr;
   } bmp_cmd_type;

   // result of the shared run check unit
   typedef struct packed {
      logic fits;
      logic free;
   } run_stat_type;

endpackage

[src/bsa_run_unit.sv]
// Shared run unit: builds the slot mask of a run and checks it against the bitmap.
module bsa_run_unit
   import bsa_pkg::*;
(
   input  logic [CAND_W-1:0]    run_start,
   input  logic [COUNT_W-1:0]   run_len,
   input  logic [LIMIT_W-1:0]   slot_limit,
   input  logic [MAX_SLOTS-1:0] occupied,
   output logic [MAX_SLOTS-1:0] run_mask,
   output run_stat_type         run_stat
);

   logic [MAX_SLOTS-1:0] run_bits;
   logic [CAND_W-1:0]    limit_ext;
   logic [CAND_W-1:0]    room;
   logic                 start_in_range;

   // build a run of len ones and move it to the start slot
   assign run_bits       = (MAX_SLOTS'(1) << run_len) - MAX_SLOTS'(1);
   assign start_in_range = (run_start[CAND_W-1:SLOT_W] == '0);
   assign run_mask       = start_in_range ? (run_bits << run_start[SLOT_W-1:0]) : '0;

   // run must start below the limit and end at or before it
   assign limit_ext     = {1'b0, slot_limit};
   assign room          = limit_ext - run_start;
   assign run_stat.fits = (run_start < limit_ext) && (CAND_W'(run_len) <= room);
   assign run_stat.free = run_stat.fits && ((occupied & run_mask) == '0);

endmodule

[src/bsa_ctrl.sv]
// Sequencer: holds the transaction, steps search candidates, registers the result.
`include "bitmap_slot_allocator_unit_defines.svh"

module bsa_ctrl
   import bsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic               req_use_given_offset,
   input  logic [SLOT_W-1:0]  req_offset,
   input  logic [COUNT_W-1:0] req_count,
   input  logic [ALIGN_W-1:0] req_align,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [SLOT_W-1:0]  rsp_found_offset,
   output logic [CAND_W-1:0]  run_start,
   output logic [COUNT_W-1:0] run_len,
   input  run_stat_type       run_stat,
   output bmp_cmd_type        bmp_cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic               state_ff, state_in;
   logic               kind_ff, kind_in;
   logic               given_ff, given_in;
   logic [SLOT_W-1:0]  offset_ff, offset_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]  rsp_off_ff, rsp_off_in;

   logic               accept;
   logic               count_bad;
   logic               fin;
   logic               fin_ok;
   logic [SLOT_W-1:0]  fin_off;
   logic               do_set;
   logic               do_clr;
   logic               out_free;
   logic               load;
   logic [ALIGN_W-1:0] align_eff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign count_bad = (count_ff == '0) || (count_ff > COUNT_W'(MAX_RUN));
   assign align_eff = (align_ff == '0) ? ALIGN_W'(1) : align_ff;

   // search walks candidates, fixed reserve and release use the given offset
   assign run_start = (kind_ff == KIND_RESERVE && !given_ff) ? cand_ff : CAND_W'(offset_ff);
   assign run_len   = count_ff;

   // decide the outcome of this cycle's check
   always_comb begin
      fin     = 1'b0;
      fin_ok  = 1'b0;
      fin_off = '0;
      do_set  = 1'b0;
      do_clr  = 1'b0;
      if (state_ff == S_RUN) begin
         priority if (kind_ff == KIND_RELEASE) begin
            fin    = 1'b1;
            fin_ok = 1'b1;
            do_clr = 1'b1;
         end else if (count_bad) begin
            fin = 1'b1;
         end else if (given_ff) begin
            fin     = 1'b1;
            fin_ok  = run_stat.free;
            fin_off = run_stat.free ? offset_ff : '0;
            do_set  = run_stat.free;
         end else if (!run_stat.fits) begin
            fin = 1'b1;
         end else if (run_stat.free) begin
            fin     = 1'b1;
            fin_ok  = 1'b1;
            fin_off = cand_ff[SLOT_W-1:0];
            do_set  = 1'b1;
         end else begin
            // busy candidate, step on to the next one
            fin = 1'b0;
         end
      end
   end

   // commit only when the result can be stored
   assign load        = fin && out_free;
   assign bmp_cmd.set = load && do_set;
   assign bmp_cmd.clr = load && do_clr;

   // capture the transaction, advance the candidate, hold on a full output
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      given_in  = given_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      align_in  = align_ff;
      cand_in   = cand_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_RUN;
               kind_in   = req_kind;
               given_in  = req_use_given_offset;
               offset_in = req_offset;
               count_in  = req_count;
               align_in  = req_align;
               cand_in   = '0;
            end
         end
         S_RUN: begin
            if (load) begin
               state_in = S_IDLE;
            end else if (!fin) begin
               cand_in = cand_ff + CAND_W'(align_eff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_off_in   = rsp_off_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = fin_ok;
         rsp_off_in   = fin_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      given_ff   <= given_in;
      offset_ff  <= offset_in;
      count_ff   <= count_in;
      align_ff   <= align_in;
      cand_ff    <= cand_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_off_ff <= rsp_off_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_found_offset = rsp_off_ff;

   // a marked run always reports success
   `BSA_ASSERT_NEXT(a_set_gives_ok, clock, reset, bmp_cmd.set, rsp_valid_ff && rsp_ok_ff)
   // a release reports success at offset zero
   `BSA_ASSERT_NEXT(a_clr_result, clock, reset, bmp_cmd.clr,
                    rsp_valid_ff && rsp_ok_ff && rsp_off_ff == '0)
   // a failed reserve reports offset zero
   `BSA_ASSERT_NOW(a_fail_offset, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_off_ff == '0)
   // the search candidate only moves forward
   `BSA_ASSERT_NEXT(a_cand_rises, clock, reset, state_ff == S_RUN && !fin,
                    cand_ff > $past(cand_ff))

endmodule

[src/bitmap_slot_allocator_unit.sv]
// A release or fixed reserve takes a single check in the shared run unit; rsp_valid is registered.
// A first-fit search checks one candidate offset per cycle in the shared run unit and
// tries at most min(total_slots, 64) + 1 candidates (the last one fails the fit).
// Transactions do not overlap: req_ready is low while one is in
// progress, and a result held back by rsp_ready low stalls the next one.
// Reset (synchronous, active high) frees every slot at once and sets total_slots to 64.
module bitmap_slot_allocator_unit
   import bsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic               req_use_given_offset,
   input  logic [SLOT_W-1:0]  req_offset,
   input  logic [COUNT_W-1:0] req_count,
   input  logic [ALIGN_W-1:0] req_align,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [SLOT_W-1:0]  rsp_found_offset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0]   total_slots_ff, total_slots_in;
   logic [MAX_SLOTS-1:0] occupied_ff, occupied_in;
   logic [LIMIT_W-1:0]   slot_limit;
   logic [CAND_W-1:0]    run_start;
   logic [COUNT_W-1:0]   run_len;
   logic [MAX_SLOTS-1:0] run_mask;
   run_stat_type         run_stat;
   bmp_cmd_type          bmp_cmd;

   // total_slots register; the limit taken from it is clamped to the bitmap size
   assign total_slots_in = csr_wr_en ? csr_wr_data : total_slots_ff;
   assign slot_limit     = (total_slots_ff > LIMIT_W'(MAX_SLOTS)) ?
                           LIMIT_W'(MAX_SLOTS) : total_slots_ff;

   // mark or free the run chosen by the sequencer
   always_comb begin
      occupied_in = occupied_ff;
      if (bmp_cmd.set) begin
         occupied_in = occupied_ff | run_mask;
      end else if (bmp_cmd.clr) begin
         occupied_in = occupied_ff & ~run_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_slots_ff <= TOTAL_SLOTS_RESET;
         occupied_ff    <= '0;
      end else begin
         total_slots_ff <= total_slots_in;
         occupied_ff    <= occupied_in;
      end
   end

   bsa_run_unit u_run (
      .run_start  (run_start),
      .run_len    (run_len),
      .slot_limit (slot_limit),
      .occupied   (occupied_ff),
      .run_mask   (run_mask),
      .run_stat   (run_stat)
   );

   bsa_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_use_given_offset (req_use_given_offset),
      .req_offset           (req_offset),
      .req_count            (req_count),
      .req_align            (req_align),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_found_offset     (rsp_found_offset),
      .run_start            (run_start),
      .run_len              (run_len),
      .run_stat             (run_stat),
      .bmp_cmd              (bmp_cmd)
   );

endmodule

[bench/bsa_grant_checker.sv]
// Checker for the slot allocator: mirrors the occupancy bitmap and compares every response.
`timescale 1ns / 1ps
module bsa_grant_checker
   import bsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_kind,
   input  logic               req_use_given_offset,
   input  logic [SLOT_W-1:0]  req_offset,
   input  logic [COUNT_W-1:0] req_count,
   input  logic [ALIGN_W-1:0] req_align,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_ok,
   input  logic [SLOT_W-1:0]  rsp_found_offset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output int                 fail_count,
   output int                 grants_pending
);

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] found_offset;
   } grant_type;

   logic [MAX_SLOTS-1:0] slot_busy;
   logic [LIMIT_W-1:0]   total_slots;
   grant_type            pending_grants[$];
   int                   errors;

   // True when slots start .. start+len-1 all lie below lim and are free
   function automatic bit run_is_free(input int start, input int len, input int lim);
      if (start >= lim || len > lim - start) begin
         return 1'b0;
      end
      for (int i = start; i < start + len; i++) begin
         if (slot_busy[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void claim_run(input int start, input int len);
      for (int i = start; i < start + len && i < MAX_SLOTS; i++) begin
         slot_busy[i] = 1'b1;
      end
   endfunction

   // Work out the grant for one transaction and update the mirrored bitmap
   function automatic grant_type predict_allocation(
      input logic               kind,
      input logic               given,
      input logic [SLOT_W-1:0]  offset,
      input logic [COUNT_W-1:0] count,
      input logic [ALIGN_W-1:0] align
   );
      grant_type g;
      int        lim;
      int        off_i;
      int        cnt_i;
      int        step;
      int        cand;
      g     = '0;
      off_i = int'(offset);
      cnt_i = int'(count);
      lim   = (int'(total_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(total_slots);
      if (kind == KIND_RELEASE) begin
         // clear whatever part of the run lies inside the bitmap
         for (int i = off_i; i < off_i + cnt_i && i < MAX_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
         end
         g.ok = 1'b1;
      end else if (cnt_i >= 1 && cnt_i <= MAX_RUN) begin
         if (given) begin
            // check the whole run before marking anything
            if (run_is_free(off_i, cnt_i, lim)) begin
               claim_run(off_i, cnt_i);
               g.ok           = 1'b1;
               g.found_offset = offset;
            end
         end else begin
            // first fit over multiples of the step
            step = (align == '0) ? 1 : int'(align);
            cand = 0;
            while (cand < lim && cnt_i <= lim - cand) begin
               if (run_is_free(cand, cnt_i, lim)) begin
                  claim_run(cand, cnt_i);
                  g.ok           = 1'b1;
                  g.found_offset = SLOT_W'(cand);
                  break;
               end
               cand += step;
            end
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin : watch_channels
      grant_type want;
      if (reset) begin
         slot_busy   = '0;
         total_slots = TOTAL_SLOTS_RESET;
         pending_grants.delete();
      end else begin
         if (csr_wr_en) begin
            total_slots = csr_wr_data;
         end
         // compare a delivered response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               $display("%0t: unexpected response ok %0b found_offset %0d",
                        $time, rsp_ok, rsp_found_offset);
               errors++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
                  errors++;
               end
               if (rsp_found_offset !== want.found_offset) begin
                  $display("%0t: found_offset expected %0d actual %0d",
                           $time, want.found_offset, rsp_found_offset);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_grants.push_back(predict_allocation(req_kind, req_use_given_offset,
                                                        req_offset, req_count, req_align));
         end
      end
      fail_count     <= errors;
      grants_pending <= pending_grants.size();
   end

endmodule

[bench/bitmap_slot_allocator_unit_tb.sv]
// Testbench top for the slot allocator: drives transactions and configuration, gives the verdict.
`timescale 1ns / 1ps
module bitmap_slot_allocator_unit_tb;
   import bsa_pkg::*;

   localparam int CYCLE_LIMIT     = 1_200_000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [SLOT_W-1:0]  off;
      logic [COUNT_W-1:0] cnt;
   } run_type;

   logic               clock                = 1'b0;
   logic               reset                = 1'b1;
   logic               req_valid            = 1'b0;
   logic               req_ready;
   logic               req_kind             = KIND_RESERVE;
   logic               req_use_given_offset = 1'b0;
   logic [SLOT_W-1:0]  req_offset           = '0;
   logic [COUNT_W-1:0] req_count            = '0;
   logic [ALIGN_W-1:0] req_align            = '0;
   logic               rsp_valid;
   logic               rsp_ready            = 1'b0;
   logic               rsp_ok;
   logic [SLOT_W-1:0]  rsp_found_offset;
   logic               csr_wr_en            = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data          = '0;

   int      fail_count;
   int      grants_pending;
   int      cycle_count = 0;
   bit      steady      = 1'b0;
   bit      hold_off_req = 1'b0;
   run_type claimed_runs[$];

   bitmap_slot_allocator_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_use_given_offset (req_use_given_offset),
      .req_offset           (req_offset),
      .req_count            (req_count),
      .req_align            (req_align),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_found_offset     (rsp_found_offset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   bsa_grant_checker grant_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_use_given_offset (req_use_given_offset),
      .req_offset           (req_offset),
      .req_count            (req_count),
      .req_align            (req_align),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_found_offset     (rsp_found_offset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .fail_count           (fail_count),
      .grants_pending       (grants_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none in a steady stretch
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Response side: random stalls, plus a long hold-off on request
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Give up at the cycle limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bitmap_slot_allocator_unit_tb NOT OK");
      $finish;
   end

   // Offer one transaction and hold it until accepted
   task automatic send_alloc(
      input logic               kind,
      input logic               given,
      input logic [SLOT_W-1:0]  off,
      input logic [COUNT_W-1:0] cnt,
      input logic [ALIGN_W-1:0] aln
   );
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_kind             <= kind;
      req_use_given_offset <= given;
      req_offset           <= off;
      req_count            <= cnt;
      req_align            <= aln;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding response
   task automatic await_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grants_pending != 0) @(posedge clock);
   endtask

   task automatic write_total_slots(input logic [LIMIT_W-1:0] value);
      await_drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly claim-then-free runs with plausible sizes, some malformed noise
   task automatic send_random_alloc();
      logic               kind;
      logic               given;
      logic [SLOT_W-1:0]  off;
      logic [COUNT_W-1:0] cnt;
      logic [ALIGN_W-1:0] aln;
      run_type            run;
      int                 r;
      int                 pick;
      kind  = ($urandom_range(0, 99) < 55) ? KIND_RESERVE : KIND_RELEASE;
      given = 1'($urandom_range(0, 1));
      off   = SLOT_W'($urandom_range(0, 63));
      r     = $urandom_range(0, 99);
      if (r < 60) begin
         cnt = COUNT_W'($urandom_range(1, 8));
      end else if (r < 88) begin
         cnt = COUNT_W'($urandom_range(9, 32));
      end else begin
         cnt = COUNT_W'($urandom_range(0, 63));
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
         aln = ALIGN_W'(1) << $urandom_range(0, 3);
      end else if (r < 90) begin
         aln = ALIGN_W'($urandom_range(1, 16));
      end else begin
         aln = ALIGN_W'($urandom_range(0, 127));
      end
      // free a run claimed earlier where one is known
      if (kind == KIND_RELEASE && claimed_runs.size() > 0 && $urandom_range(0, 99) < 60) begin
         pick = $urandom_range(0, claimed_runs.size() - 1);
         run  = claimed_runs[pick];
         claimed_runs.delete(pick);
         off  = run.off;
         cnt  = run.cnt;
      end
      if (kind == KIND_RESERVE && given && claimed_runs.size() < 32) begin
         run.off = off;
         run.cnt = cnt;
         claimed_runs.push_back(run);
      end
      send_alloc(kind, given, off, cnt, aln);
   endtask

   initial begin : stimulus
      logic [LIMIT_W-1:0] phase_total;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fixed reserves at the top edge, no partial marks on failure
      send_alloc(KIND_RESERVE, 1'b1, 63, 1, 1);
      send_alloc(KIND_RESERVE, 1'b1, 62, 2, 1);
      send_alloc(KIND_RESERVE, 1'b1, 62, 1, 1);
      send_alloc(KIND_RESERVE, 1'b1, 33, 32, 1);
      send_alloc(KIND_RESERVE, 1'b1, 32, 30, 1);
      // search with zero align, an align of 64, bad counts
      send_alloc(KIND_RESERVE, 1'b0, 0, 32, 0);
      send_alloc(KIND_RESERVE, 1'b0, 0, 1, 64);
      send_alloc(KIND_RESERVE, 1'b0, 0, 0, 1);
      send_alloc(KIND_RESERVE, 1'b0, 0, 33, 1);
      send_alloc(KIND_RESERVE, 1'b1, 5, 63, 1);
      // release past the end with an oversize count and the flag set
      send_alloc(KIND_RELEASE, 1'b1, 60, 63, 127);
      send_alloc(KIND_RELEASE, 1'b0, 10, 0, 1);
      send_alloc(KIND_RESERVE, 1'b0, 0, 4, 127);
      send_alloc(KIND_RESERVE, 1'b0, 0, 4, 4);
      send_alloc(KIND_RELEASE, 1'b0, 0, 32, 1);
      send_alloc(KIND_RESERVE, 1'b0, 0, 5, 3);
      send_alloc(KIND_RESERVE, 1'b0, 0, 5, 3);

      // no slots at all: every reserve fails, release still clears
      write_total_slots(0);
      send_alloc(KIND_RESERVE, 1'b0, 0, 1, 1);
      send_alloc(KIND_RESERVE, 1'b1, 0, 1, 1);
      send_alloc(KIND_RELEASE, 1'b0, 0, 63, 1);

      // a single slot
      write_total_slots(1);
      send_alloc(KIND_RESERVE, 1'b1, 0, 1, 1);
      send_alloc(KIND_RESERVE, 1'b0, 0, 1, 1);
      send_alloc(KIND_RESERVE, 1'b1, 1, 1, 1);

      // oversize limit behaves as the full bitmap
      write_total_slots(127);
      send_alloc(KIND_RESERVE, 1'b1, 63, 1, 1);
      send_alloc(KIND_RELEASE, 1'b0, 0, 63, 0);
      send_alloc(KIND_RELEASE, 1'b0, 63, 1, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_total = 64;
            1: phase_total = 48;
            2: phase_total = 127;
            3: phase_total = 17;
            default: phase_total = LIMIT_W'($urandom_range(1, 127));
         endcase
         write_total_slots(phase_total);
         steady = (phase == 2);
         // hold the response side off while transactions keep coming
         if (phase == 3) begin
            hold_off_req = 1'b1;
            for (int k = 0; k < 4; k++) begin
               send_random_alloc();
            end
            await_drain();
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_alloc();
         end
      end

      await_drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("bitmap_slot_allocator_unit_tb OK");
      end else begin
         $display("bitmap_slot_allocator_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

[bitmap_slot_allocator_unit.f]
+incdir+src
src/bsa_pkg.sv
src/bsa_run_unit.sv
src/bsa_ctrl.sv
src/bitmap_slot_allocator_unit.sv
bench/bsa_grant_checker.sv
bench/bitmap_slot_allocator_unit_tb.sv
